/* hdl/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg: shared types and constants of the multi-waveform oscillator
// Register indexes, mode codes, controller/datapath interface structs and
// the quarter-wave sine ROM contents.
// ----------------------------------------------------------------------------
package mwo_pkg;

    // Quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

    // Configuration register indexes
    localparam logic [2:0] REG_MODE           = 3'd0;
    localparam logic [2:0] REG_PHASE_STEP     = 3'd1;
    localparam logic [2:0] REG_WIDTH          = 3'd2;
    localparam logic [2:0] REG_RISE_SLOPE     = 3'd3;
    localparam logic [2:0] REG_FALL_SLOPE     = 3'd4;
    localparam logic [2:0] REG_PERIOD_SAMPLES = 3'd5;
    localparam logic [2:0] REG_USE_INPUT      = 3'd6;

    // Waveform modes
    localparam logic [1:0] MODE_SINE     = 2'd0;
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_PULSE    = 2'd2;
    localparam logic [1:0] MODE_IMPULSE  = 2'd3;

    // Register reset values
    localparam logic [31:0] RST_PHASE_STEP     = 32'd42852281;
    localparam logic [23:0] RST_FALL_SLOPE     = 24'd131072;
    localparam logic [23:0] RST_PERIOD_SAMPLES = 24'd100;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the microphone sample of an accepted transaction
        logic load_prod; // register the shared multiplier output
        logic sel_mix;   // multiplier operands: 0 waveform slope, 1 mic mix
        logic shape;     // register the generated waveform sample
        logic finish;    // load the output register and advance phase/counter
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register empty or draining this cycle
    } t_status;

    typedef logic [SINE_TABLE_DEPTH-1:0][15:0] t_sine_rom;

    // Build the quarter-wave table with an integer Taylor series in Q2.30,
    // then round to Q1.15 and cap at full scale.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        rom = '0;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            term = x;
            sum  = signed'(x);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd210;
            sum  = sum - signed'(term);
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'd272;
            sum  = sum + signed'(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = (unsigned'(sum) + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            rom[i] = r[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

/* hdl/multi_waveform_oscillator.sv */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator: direct digital synthesis waveform generator
// Sine, triangle/saw, pulse and impulse in Q1.15, optionally mixed with the
// microphone sample of each audio frame.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction passes slope multiply, shape, mic mix and
//   output load to o_valid; the output register frees the working path.
// Intake: a new transaction is taken only when idle or as the current one
//   leaves, as the single shared multiplier serves slope and mic mix in turn.
// Reset (synchronous, i_rst_n low): phase and impulse counter clear,
//   registers take their reset values, the output empties, both ports stall.
module multi_waveform_oscillator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_mic_sample,
    // sample output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_sample,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    mwo_pkg::t_cmd    cmd;
    mwo_pkg::t_status status;
    logic             cfg_we;

    // Takes writes out of reset; host must only write while idle, unchecked here
    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Controller: walk each transaction through slope multiply, shape, mix, load
    mwo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: registers, phase accumulator, shared multiplier, output register
    mwo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mic_sample (i_mic_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_sample (o_out_sample),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule

/* hdl/mwo_ctrl.sv */
// ----------------------------------------------------------------------------
// mwo_ctrl: sequencing controller of the multi-waveform oscillator
// Steps each accepted transaction through slope multiply, shaping, mic mix
// and output load, and drives the input stall.
// ----------------------------------------------------------------------------
module mwo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mwo_pkg::t_status i_status,
    output mwo_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GEN    = 3'd1;
    localparam logic [2:0] S_SHAPE  = 3'd2;
    localparam logic [2:0] S_MIX    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       can_take;
    logic       accept;

    // A new transaction enters when idle, or as the current one leaves
    assign can_take = (r_state == S_IDLE) ||
                      ((r_state == S_FINISH) && i_status.out_free);
    assign o_stall  = !i_rst_n || !can_take;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_GEN;
            end
            S_GEN:   n_state = S_SHAPE;
            S_SHAPE: n_state = S_MIX;
            S_MIX:   n_state = S_FINISH;
            S_FINISH: begin
                if (i_status.out_free) n_state = accept ? S_GEN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.load_prod = (r_state == S_GEN) || (r_state == S_MIX);
        o_cmd.sel_mix   = (r_state == S_MIX);
        o_cmd.shape     = (r_state == S_SHAPE);
        o_cmd.finish    = (r_state == S_FINISH) && i_status.out_free;
    end

endmodule

/* hdl/mwo_dp.sv */
// ----------------------------------------------------------------------------
// mwo_dp: datapath of the multi-waveform oscillator
// Configuration registers, phase accumulator, impulse counter, shared
// multiplier, waveform shaping and the output register.
// ----------------------------------------------------------------------------
module mwo_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // sample path
    input  logic signed [15:0] i_mic_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_sample,
    // control
    input  mwo_pkg::t_cmd      i_cmd,
    output mwo_pkg::t_status   o_status
);

    localparam int IW = mwo_pkg::SINE_IDX_W;

    // configuration registers
    logic [1:0]  r_mode;
    logic [31:0] r_phase_step;
    logic [16:0] r_width;
    logic [23:0] r_rise_slope;
    logic [23:0] r_fall_slope;
    logic [23:0] r_period_samples;
    logic        r_use_input;

    // oscillator state
    logic [31:0] r_phase;
    logic [23:0] r_count;

    // working registers
    logic signed [15:0] r_mic;
    logic signed [58:0] r_prod;
    logic signed [15:0] r_gen;
    logic signed [15:0] r_out_sample;
    logic               r_out_valid;

    logic [16:0]        w_clamp;
    logic [32:0]        w_lim;
    logic               rising;
    logic [32:0]        fall_arg;
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic [24:0]        tri_q;
    logic signed [15:0] tri_val;
    logic [IW+29:0]     sine_scaled;
    logic [IW-1:0]      sine_idx_raw;
    logic [IW-1:0]      sine_idx;
    logic [15:0]        sine_mag;
    logic signed [15:0] sine_val;
    logic signed [15:0] pulse_val;
    logic signed [15:0] impulse_val;
    logic signed [15:0] n_gen;
    logic signed [43:0] mix_full;
    logic signed [15:0] mix_val;
    logic signed [15:0] n_out_sample;
    logic [23:0]        period_eff;
    logic [24:0]        count_inc;
    logic               out_free;

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= mwo_pkg::MODE_SINE;
            r_phase_step     <= mwo_pkg::RST_PHASE_STEP;
            r_width          <= '0;
            r_rise_slope     <= '0;
            r_fall_slope     <= mwo_pkg::RST_FALL_SLOPE;
            r_period_samples <= mwo_pkg::RST_PERIOD_SAMPLES;
            r_use_input      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwo_pkg::REG_MODE:           r_mode           <= i_cfg_data[1:0];
                mwo_pkg::REG_PHASE_STEP:     r_phase_step     <= i_cfg_data;
                mwo_pkg::REG_WIDTH:          r_width          <= i_cfg_data[16:0];
                mwo_pkg::REG_RISE_SLOPE:     r_rise_slope     <= i_cfg_data[23:0];
                mwo_pkg::REG_FALL_SLOPE:     r_fall_slope     <= i_cfg_data[23:0];
                mwo_pkg::REG_PERIOD_SAMPLES: r_period_samples <= i_cfg_data[23:0];
                mwo_pkg::REG_USE_INPUT:      r_use_input      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- shared multiplier operands ----
    assign w_clamp  = (r_width > 17'd65536) ? 17'd65536 : r_width;
    assign w_lim    = {w_clamp, 16'd0};
    assign rising   = w_clamp[16] || ({1'b0, r_phase} < w_lim);
    assign fall_arg = 33'h1_0000_0000 - {1'b0, r_phase};

    always_comb begin
        if (i_cmd.sel_mix) begin
            mul_a = {{18{r_gen[15]}}, r_gen};
            mul_b = {{9{r_mic[15]}}, r_mic};
        end else begin
            mul_a = rising ? {2'b00, r_phase} : {1'b0, fall_arg};
            mul_b = {1'b0, (rising ? r_rise_slope : r_fall_slope)};
        end
    end

    // ---- waveform shaping ----
    // Slope product shifted right 33, less half scale, clamped at the top
    assign tri_q   = r_prod[57:33];
    assign tri_val = (tri_q >= 25'd65536) ? 16'sh7fff : signed'({~tri_q[15], tri_q[14:0]});

    // Quarter-wave lookup: mirror the index in odd quadrants, negate in the upper phase half
    assign sine_scaled  = (IW + 30)'(r_phase[29:0]) * (IW + 30)'(mwo_pkg::SINE_TABLE_DEPTH);
    assign sine_idx_raw = sine_scaled[IW+29:30];
    assign sine_idx     = r_phase[30] ? (IW'(mwo_pkg::SINE_TABLE_DEPTH - 1) - sine_idx_raw)
                                      : sine_idx_raw;
    assign sine_mag     = mwo_pkg::SINE_ROM[sine_idx];
    assign sine_val     = r_phase[31] ? signed'(16'(-sine_mag)) : signed'(sine_mag);

    assign pulse_val   = ({1'b0, r_phase} <= w_lim) ? 16'sh7fff : 16'sh8000;
    assign impulse_val = (r_count == 24'd0) ? 16'sh7fff : 16'sh0000;

    always_comb begin
        unique case (r_mode)
            mwo_pkg::MODE_SINE:     n_gen = sine_val;
            mwo_pkg::MODE_TRIANGLE: n_gen = tri_val;
            mwo_pkg::MODE_PULSE:    n_gen = pulse_val;
            mwo_pkg::MODE_IMPULSE:  n_gen = impulse_val;
            default:                n_gen = impulse_val;
        endcase
    end

    // ---- mic mix: floor of product over 2^15, clamped ----
    assign mix_full = r_prod[58:15];
    always_comb begin
        priority if (mix_full > 44'sd32767) begin
            mix_val = 16'sh7fff;
        end else if (mix_full < -44'sd32768) begin
            mix_val = 16'sh8000;
        end else begin
            mix_val = mix_full[15:0];
        end
    end
    assign n_out_sample = r_use_input ? mix_val : r_gen;

    // ---- impulse counter wrap ----
    assign period_eff = (r_period_samples == 24'd0) ? 24'd1 : r_period_samples;
    assign count_inc  = {1'b0, r_count} + 25'd1;

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture)   r_mic  <= i_mic_sample;
        if (i_cmd.load_prod) r_prod <= 59'(mul_a * mul_b);
        if (i_cmd.shape)     r_gen  <= n_gen;
        if (i_cmd.finish)    r_out_sample <= n_out_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_phase <= r_phase + r_phase_step;
            r_count <= (count_inc >= {1'b0, period_eff}) ? 24'd0 : count_inc[23:0];
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_sample      = r_out_sample;
    assign o_status.out_free = out_free;

endmodule

/* hdl/mwo_chk.sv */
// ----------------------------------------------------------------------------
// mwo_chk: port-level checker of the multi-waveform oscillator
// Tracks transactions in flight and checks ordering and spacing at the ports.
// ----------------------------------------------------------------------------
module mwo_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_out_sample
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Count transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_sample))
        else $error("stalled result changed or dropped");

    // Busy for the cycle after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("input taken in back-to-back cycles");

    // No result without a transaction in flight
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 2'd0)
        else $error("result without a pending transaction");

    // At most one in the working path and one in the output register
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many transactions in flight");

endmodule

bind multi_waveform_oscillator mwo_chk u_mwo_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_sample (o_out_sample)
);
